// ===== src/calendar_date_subtractor_assert.svh =====
// Assertion macros for the date subtractor.
`ifndef CALENDAR_DATE_SUBTRACTOR_ASSERT_SVH
`define CALENDAR_DATE_SUBTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define CDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cds_pkg.sv =====
package cds_pkg;

  localparam int ACT_W   = 4;
  localparam int AMT_W   = 15;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int RES_W   = 9;   // |year| mod 400
  localparam int CNT_W   = 18;  // holds amount * 7
  localparam int NSUB_W  = 19;  // holds amount * 10

  localparam logic [ACT_W-1:0] ACT_DAYS           = 4'd0;
  localparam logic [ACT_W-1:0] ACT_WEEKS          = 4'd1;
  localparam logic [ACT_W-1:0] ACT_MONTHS         = 4'd2;
  localparam logic [ACT_W-1:0] ACT_YEARS_STEP     = 4'd3;
  localparam logic [ACT_W-1:0] ACT_YEARS_DIRECT   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DECADES_STEP   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DECADES_DIRECT = 4'd6;
  localparam logic [ACT_W-1:0] ACT_CENTURY        = 4'd7;
  localparam logic [ACT_W-1:0] ACT_MILLENNIUM     = 4'd8;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAY_FIRST    = 5'd1;
  localparam logic [DAY_W-1:0] DAY_FEB_COMM = 5'd28;
  localparam logic [DAY_W-1:0] DAY_FEB_LEAP = 5'd29;
  localparam logic [DAY_W-1:0] DAY_MAX      = 5'd31;

  localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [RES_W-1:0] RES_MAX     = 9'd399;
  localparam logic [RES_W:0]   LEAP_CYCLE  = 10'd400;
  localparam logic [RES_W-1:0] CENT_1      = 9'd100;
  localparam logic [RES_W-1:0] CENT_2      = 9'd200;
  localparam logic [RES_W-1:0] CENT_3      = 9'd300;

  localparam logic [CNT_W-1:0]  DAYS_PER_WEEK   = 18'd7;
  localparam logic [NSUB_W-1:0] YEARS_PER_DEC   = 19'd10;
  localparam logic [NSUB_W-1:0] YEARS_PER_CENT  = 19'd100;
  localparam logic [NSUB_W-1:0] YEARS_PER_MILL  = 19'd1000;

  typedef struct packed {
    logic load;
    logic shift;
    logic corr;
    logic step;
    logic year_sub;
    logic clamp;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic             cnt_zero;
    logic [ACT_W-1:0] act;
  } sts_t;

  // Leap test from |year| mod 400.
  function automatic logic leap_res(input logic [RES_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic lp);
    logic [MONTH_W-1:0] idx;
    idx = m - MONTH_JAN;
    if (m < MONTH_JAN || m > MONTH_DEC) return DAY_MAX;
    if (m == MONTH_FEB) return lp ? DAY_FEB_LEAP : DAY_FEB_COMM;
    return MONTH_DAYS[idx];
  endfunction

endpackage

// ===== src/calendar_date_subtractor.sv =====
// channel | signals                                            | flow
// --------+----------------------------------------------------+------------------
// in      | in_valid, in_stall, action, amount, year_in,       | word taken when
//         | month_in, day_in                                   | valid && !stall
// out     | out_valid, out_stall, year_out, month_out, day_out | same
//
// One word at a time. After accept, a serial mod-400 pass over |year| feeds the leap test;
// days and weeks then step back one day at a time and months one month at a time, stepwise
// years and decades subtract at once, and direct years and decades, century and millennium
// subtract and then make a second serial mod-400 pass of the leap test. Unused codes go
// straight to the result. in_stall drops as the result is written to the output register.
// The result sits in an output register, so a new word is taken while it waits.
// rst is synchronous and clears the controller and the output valid.
`include "calendar_date_subtractor_assert.svh"

module calendar_date_subtractor import cds_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ACT_W-1:0]             action,
  input  logic [AMT_W-1:0]             amount,
  input  logic signed [YEAR_WIDTH-1:0] year_in,
  input  logic [MONTH_W-1:0]           month_in,
  input  logic [DAY_W-1:0]             day_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [YEAR_WIDTH-1:0] year_out,
  output logic [MONTH_W-1:0]           month_out,
  output logic [DAY_W-1:0]             day_out
);

  cmd_t cmd;
  sts_t sts;
  logic [6:0] cmd_bits;

  cds_ctrl #(.YEAR_WIDTH(YEAR_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cds_datapath #(.YEAR_WIDTH(YEAR_WIDTH)) u_dp (
    .clk       (clk),
    .action    (action),
    .amount    (amount),
    .year_in   (year_in),
    .month_in  (month_in),
    .day_in    (day_in),
    .cmd       (cmd),
    .sts       (sts),
    .year_out  (year_out),
    .month_out (month_out),
    .day_out   (day_out)
  );

  assign cmd_bits = cmd;

  `CDS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "not busy after accept")
  `CDS_ASSERT_IMPL(a_cmd_onehot, clk, rst, 1'b1, $onehot0(cmd_bits), "datapath commands overlap")
  `CDS_ASSERT_IMPL(a_publish_free, clk, rst, cmd.publish, !out_valid || !out_stall, "result overwritten")
  `CDS_ASSERT_IMPL(a_date_range, clk, rst, out_valid, (day_out != '0) && (month_out != '0) && (month_out <= MONTH_DEC), "date out of range")

endmodule

// ===== src/cds_datapath.sv =====
module cds_datapath import cds_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                         clk,
  input  logic [ACT_W-1:0]             action,
  input  logic [AMT_W-1:0]             amount,
  input  logic signed [YEAR_WIDTH-1:0] year_in,
  input  logic [MONTH_W-1:0]           month_in,
  input  logic [DAY_W-1:0]             day_in,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  output logic signed [YEAR_WIDTH-1:0] year_out,
  output logic [MONTH_W-1:0]           month_out,
  output logic [DAY_W-1:0]             day_out
);

  localparam logic [YEAR_WIDTH-1:0] Y_MIN = {1'b1, {(YEAR_WIDTH-1){1'b0}}};

  logic [ACT_W-1:0]      act;
  logic [AMT_W-1:0]      amt;
  logic [YEAR_WIDTH-1:0] y;
  logic [MONTH_W-1:0]    m;
  logic [DAY_W-1:0]      d;
  logic [RES_W-1:0]      r;
  logic [YEAR_WIDTH-1:0] sh;
  logic [CNT_W-1:0]      cnt;

  logic [YEAR_WIDTH-1:0] y_res;
  logic [MONTH_W-1:0]    m_res;
  logic [DAY_W-1:0]      d_res;

  logic [YEAR_WIDTH-1:0] yin_u, yin_abs, y_dec, y_new, y_new_abs;
  logic [MONTH_W-1:0]    m_load, m_prev;
  logic [DAY_W-1:0]      len_prev, len_cur;
  logic [RES_W-1:0]      r_dec, r_mod;
  logic [RES_W:0]        rr;
  logic [NSUB_W-1:0]     nsub;
  logic [CNT_W-1:0]      cnt_load;
  logic                  leap_now, dec_mag, stepwise, feb29;

  always_comb begin
    yin_u   = $unsigned(year_in);
    yin_abs = yin_u[YEAR_WIDTH-1] ? (~yin_u + 1'b1) : yin_u;

    if (month_in < MONTH_JAN) m_load = MONTH_JAN;
    else if (month_in > MONTH_DEC) m_load = MONTH_DEC;
    else m_load = month_in;

    case (action)
      ACT_DAYS, ACT_MONTHS: cnt_load = CNT_W'(amount);
      ACT_WEEKS:            cnt_load = CNT_W'(amount) * DAYS_PER_WEEK;
      default:              cnt_load = '0;
    endcase

    m_prev   = m - MONTH_JAN;
    leap_now = leap_res(r);
    len_prev = month_len(m_prev, leap_now);
    len_cur  = month_len(m, leap_now);

    // magnitude shrinks for positive years and for the most negative one (wraps to max)
    y_dec   = y - 1'b1;
    dec_mag = (!y[YEAR_WIDTH-1] && (y != '0)) || (y == Y_MIN);
    if (dec_mag) r_dec = (r == '0) ? RES_MAX : r - 1'b1;
    else         r_dec = (r == RES_MAX) ? '0 : r + 1'b1;

    // one bit of the restoring mod-400 reduction
    rr    = {r, sh[YEAR_WIDTH-1]};
    r_mod = (rr >= LEAP_CYCLE) ? RES_W'(rr - LEAP_CYCLE) : RES_W'(rr);

    case (act)
      ACT_YEARS_STEP, ACT_YEARS_DIRECT:     nsub = NSUB_W'(amt);
      ACT_DECADES_STEP, ACT_DECADES_DIRECT: nsub = NSUB_W'(amt) * YEARS_PER_DEC;
      ACT_CENTURY:                          nsub = YEARS_PER_CENT;
      ACT_MILLENNIUM:                       nsub = YEARS_PER_MILL;
      default:                              nsub = '0;
    endcase
    y_new     = y - YEAR_WIDTH'(nsub);
    y_new_abs = y_new[YEAR_WIDTH-1] ? (~y_new + 1'b1) : y_new;
    stepwise  = (act == ACT_YEARS_STEP) || (act == ACT_DECADES_STEP);
    feb29     = (m == MONTH_FEB) && (d == DAY_FEB_LEAP);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      amt <= amount;
      y   <= yin_u;
      m   <= m_load;
      d   <= (day_in == '0) ? DAY_FIRST : day_in;
      sh  <= yin_abs;
      r   <= '0;
      cnt <= cnt_load;
    end
    if (cmd.shift) begin
      r  <= r_mod;
      sh <= sh << 1;
    end
    if (cmd.corr) begin
      if (d > len_cur) d <= len_cur;
    end
    if (cmd.step) begin
      cnt <= cnt - 1'b1;
      if (act == ACT_MONTHS) begin
        if (m == MONTH_JAN) begin
          m <= MONTH_DEC;
          y <= y_dec;
          r <= r_dec;
        end else begin
          m <= m_prev;
          if (d > len_prev) d <= len_prev;
        end
      end else if (d == DAY_FIRST) begin
        if (m == MONTH_JAN) begin
          m <= MONTH_DEC;
          d <= DAY_MAX;
          y <= y_dec;
          r <= r_dec;
        end else begin
          m <= m_prev;
          d <= len_prev;
        end
      end else begin
        d <= d - 1'b1;
      end
    end
    if (cmd.year_sub) begin
      y  <= y_new;
      sh <= y_new_abs;
      r  <= '0;
      // the first single or ten-year step off a leap year always lands in a common year
      if (stepwise && feb29 && (amt != '0)) d <= DAY_FEB_COMM;
    end
    if (cmd.clamp) begin
      if (feb29 && !leap_now) d <= DAY_FEB_COMM;
    end
    if (cmd.publish) begin
      y_res <= y;
      m_res <= m;
      d_res <= d;
    end
  end

  assign sts.cnt_zero = (cnt == '0);
  assign sts.act      = act;

  assign year_out  = $signed(y_res);
  assign month_out = m_res;
  assign day_out   = d_res;

endmodule

// ===== src/cds_ctrl.sv =====
module cds_ctrl import cds_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int BW = $clog2(YEAR_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD1  = 3'd1;
  localparam logic [2:0] ST_CORR  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_YEAR  = 3'd4;
  localparam logic [2:0] ST_MOD2  = 3'd5;
  localparam logic [2:0] ST_CLAMP = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]    state, state_next;
  logic [BW-1:0] bcnt, bcnt_next;
  logic          ovalid, ovalid_next;
  logic          stepwise;

  assign stepwise = (sts.act == ACT_YEARS_STEP) || (sts.act == ACT_DECADES_STEP);

  always_comb begin
    state_next = state;
    bcnt_next  = bcnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          bcnt_next  = BW'(YEAR_WIDTH - 1);
          state_next = ST_MOD1;
        end
      end
      ST_MOD1: begin
        cmd.shift = 1'b1;
        bcnt_next = bcnt - 1'b1;
        if (bcnt == '0) state_next = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr = 1'b1;
        unique case (sts.act) inside
          ACT_DAYS, ACT_WEEKS, ACT_MONTHS: state_next = ST_RUN;
          ACT_YEARS_STEP, ACT_YEARS_DIRECT, ACT_DECADES_STEP, ACT_DECADES_DIRECT,
          ACT_CENTURY, ACT_MILLENNIUM:     state_next = ST_YEAR;
          default:                         state_next = ST_FIN;
        endcase
      end
      ST_RUN: begin
        if (sts.cnt_zero) state_next = ST_FIN;
        else cmd.step = 1'b1;
      end
      ST_YEAR: begin
        cmd.year_sub = 1'b1;
        if (stepwise) begin
          state_next = ST_FIN;
        end else begin
          bcnt_next  = BW'(YEAR_WIDTH - 1);
          state_next = ST_MOD2;
        end
      end
      ST_MOD2: begin
        cmd.shift = 1'b1;
        bcnt_next = bcnt - 1'b1;
        if (bcnt == '0) state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!ovalid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (cmd.publish) ovalid_next = 1'b1;
    else if (!out_stall) ovalid_next = 1'b0;
    else ovalid_next = ovalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      bcnt   <= '0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      bcnt   <= bcnt_next;
      ovalid <= ovalid_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = ovalid;

endmodule

// ===== verif/date_result_checker.sv =====
`timescale 1ns / 1ps

module date_result_checker import cds_pkg::*; #(
  parameter int YEAR_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [ACT_W-1:0]             action,
  input  logic [AMT_W-1:0]             amount,
  input  logic signed [YEAR_WIDTH-1:0] year_in,
  input  logic [MONTH_W-1:0]           month_in,
  input  logic [DAY_W-1:0]             day_in,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [YEAR_WIDTH-1:0] year_out,
  input  logic [MONTH_W-1:0]           month_out,
  input  logic [DAY_W-1:0]             day_out,
  output int                           failures,
  output int                           pending,
  output int                           checked
);

  typedef struct packed {
    logic signed [YEAR_WIDTH-1:0] year;
    logic [MONTH_W-1:0]           month;
    logic [DAY_W-1:0]             day;
  } cal_date_t;

  cal_date_t expected_dates[$];
  int        fail_count = 0;
  int        match_count = 0;

  assign failures = fail_count;
  assign pending  = expected_dates.size();
  assign checked  = match_count;

  // Leap rule applies to the magnitude of negative years.
  function automatic logic is_leap(input logic signed [YEAR_WIDTH-1:0] y);
    longint mag;
    mag = (y < 0) ? -longint'(y) : longint'(y);
    return ((mag % 4 == 0) && (mag % 100 != 0)) || (mag % 400 == 0);
  endfunction

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic signed [YEAR_WIDTH-1:0] y);
    if (m == MONTH_FEB) begin
      return is_leap(y) ? DAY_FEB_LEAP : DAY_FEB_COMM;
    end
    return MONTH_DAYS[m - MONTH_JAN];
  endfunction

  function automatic cal_date_t prev_day(input cal_date_t t);
    if (t.day != DAY_FIRST) begin
      t.day = t.day - 1'b1;
    end else if (t.month == MONTH_JAN) begin
      t.month = MONTH_DEC;
      t.day   = DAY_MAX;
      t.year  = t.year - 1'b1;
    end else begin
      t.month = t.month - 1'b1;
      t.day   = days_in_month(t.month, t.year);
    end
    return t;
  endfunction

  function automatic cal_date_t prev_month(input cal_date_t t);
    logic [DAY_W-1:0] len;
    if (t.month == MONTH_JAN) begin
      t.month = MONTH_DEC;
      t.year  = t.year - 1'b1;
    end else begin
      t.month = t.month - 1'b1;
    end
    len = days_in_month(t.month, t.year);
    if (t.day > len) t.day = len;
    return t;
  endfunction

  function automatic cal_date_t minus_years(input cal_date_t t, input logic [31:0] n);
    t.year = t.year - n[YEAR_WIDTH-1:0];
    if (t.month == MONTH_FEB && t.day == DAY_FEB_LEAP && !is_leap(t.year)) t.day = DAY_FEB_COMM;
    return t;
  endfunction

  function automatic cal_date_t earlier_date(input logic [ACT_W-1:0] act,
                                             input logic [AMT_W-1:0] amt,
                                             input logic signed [YEAR_WIDTH-1:0] y,
                                             input logic [MONTH_W-1:0] m,
                                             input logic [DAY_W-1:0] d);
    cal_date_t        t;
    logic [DAY_W-1:0] len;
    // out-of-range month/day are pulled into range first
    t.year  = y;
    t.month = (m < MONTH_JAN) ? MONTH_JAN : (m > MONTH_DEC) ? MONTH_DEC : m;
    t.day   = (d < DAY_FIRST) ? DAY_FIRST : d;
    len = days_in_month(t.month, t.year);
    if (t.day > len) t.day = len;
    case (act)
      ACT_DAYS:           repeat (int'(amt)) t = prev_day(t);
      ACT_WEEKS:          repeat (int'(amt) * int'(DAYS_PER_WEEK)) t = prev_day(t);
      ACT_MONTHS:         repeat (int'(amt)) t = prev_month(t);
      ACT_YEARS_STEP:     repeat (int'(amt)) t = minus_years(t, 32'd1);
      ACT_YEARS_DIRECT:   t = minus_years(t, 32'(amt));
      ACT_DECADES_STEP:   repeat (int'(amt)) t = minus_years(t, 32'(YEARS_PER_DEC));
      ACT_DECADES_DIRECT: t = minus_years(t, 32'(amt) * 32'(YEARS_PER_DEC));
      ACT_CENTURY:        t = minus_years(t, 32'(YEARS_PER_CENT));
      ACT_MILLENNIUM:     t = minus_years(t, 32'(YEARS_PER_MILL));
      default:            ;
    endcase
    return t;
  endfunction

  always @(posedge clk) begin
    cal_date_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_dates.push_back(earlier_date(action, amount, year_in, month_in, day_in));
      end
      if (out_valid && !out_stall) begin
        if (expected_dates.size() == 0) begin
          $error("result word with nothing expected: %0d-%0d-%0d", year_out, month_out, day_out);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          match_count++;
          if (year_out !== want.year) begin
            $error("year_out: expected %0d, got %0d", want.year, year_out);
            fail_count++;
          end
          if (month_out !== want.month) begin
            $error("month_out: expected %0d, got %0d", want.month, month_out);
            fail_count++;
          end
          if (day_out !== want.day) begin
            $error("day_out: expected %0d, got %0d", want.day, day_out);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_calendar_date_subtractor.sv =====
`timescale 1ns / 1ps

module tb_calendar_date_subtractor;
  import cds_pkg::*;

  localparam int YEAR_WIDTH   = 16;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int TAIL_CYCLES  = 64;
  localparam int RANDOM_WORDS = 400;
  localparam int NOTABLE_YEARS [10] = '{0, -1, 1, 100, -100, 400, -400, 2000, 32767, -32768};

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [ACT_W-1:0]             action = '0;
  logic [AMT_W-1:0]             amount = '0;
  logic signed [YEAR_WIDTH-1:0] year_in = '0;
  logic [MONTH_W-1:0]           month_in = MONTH_JAN;
  logic [DAY_W-1:0]             day_in = DAY_FIRST;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [YEAR_WIDTH-1:0] year_out;
  logic [MONTH_W-1:0]           month_out;
  logic [DAY_W-1:0]             day_out;

  int failures;
  int pending;
  int checked;
  int cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int directed_words = 0;
  logic [15:0] units_seen = '0;

  calendar_date_subtractor #(.YEAR_WIDTH(YEAR_WIDTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .amount(amount), .year_in(year_in), .month_in(month_in), .day_in(day_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .year_out(year_out), .month_out(month_out), .day_out(day_out)
  );

  date_result_checker #(.YEAR_WIDTH(YEAR_WIDTH)) u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .amount(amount), .year_in(year_in), .month_in(month_in), .day_in(day_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .year_out(year_out), .month_out(month_out), .day_out(day_out),
    .failures(failures), .pending(pending), .checked(checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, pending);
    $display("tb_calendar_date_subtractor failed");
    $finish;
  end

  // receiver: stall style changes at random after each phase of random length
  initial begin
    stall_style_t style;
    int           phase_len;
    forever begin
      style     = stall_style_t'($urandom_range(STALL_NONE, STALL_HEAVY));
      phase_len = $urandom_range(50, 400);
      for (int k = 0; k < phase_len; k++) begin
        @(negedge clk);
        case (style)
          STALL_NONE:     out_stall = 1'b0;
          STALL_COIN:     out_stall = $urandom_range(0, 1);
          STALL_PERIODIC: out_stall = (k % 8) < 3;
          default:        out_stall = ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  // one word, with a random gap at the start of each burst
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [AMT_W-1:0] amt,
                           input logic signed [YEAR_WIDTH-1:0] yr,
                           input logic [MONTH_W-1:0] mon, input logic [DAY_W-1:0] dy);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    action   = act;
    amount   = amt;
    year_in  = yr;
    month_in = mon;
    day_in   = dy;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    units_seen[act] = 1'b1;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_word();
    logic [ACT_W-1:0]             act;
    logic [AMT_W-1:0]             amt;
    logic signed [YEAR_WIDTH-1:0] yr;
    logic [MONTH_W-1:0]           mon;
    logic [DAY_W-1:0]             dy;
    int                           pick;
    if ($urandom_range(0, 9) == 0) act = $urandom_range(ACT_MILLENNIUM + 1, {ACT_W{1'b1}});
    else act = $urandom_range(ACT_DAYS, ACT_MILLENNIUM);

    // stepped units cost a cycle per step, so big counts are rare there
    case (act)
      ACT_YEARS_DIRECT, ACT_DECADES_DIRECT, ACT_CENTURY, ACT_MILLENNIUM: amt = $urandom;
      ACT_WEEKS: amt = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 2000)
                                                     : $urandom_range(0, 60);
      default: begin
        pick = $urandom_range(0, 99);
        if (pick == 0) amt = $urandom;
        else if (pick < 25) amt = $urandom_range(0, 1000);
        else amt = $urandom_range(0, 40);
      end
    endcase

    pick = $urandom_range(0, 9);
    if (pick < 4) yr = $urandom;
    else yr = NOTABLE_YEARS[$urandom_range(0, 9)] + $urandom_range(0, 8) - 4;

    if ($urandom_range(0, 9) == 0) mon = $urandom_range(0, 15);
    else mon = $urandom_range(MONTH_JAN, MONTH_DEC);

    pick = $urandom_range(0, 19);
    if (pick < 12) dy = $urandom_range(DAY_FIRST, DAY_FEB_COMM);
    else if (pick < 16) dy = $urandom_range(DAY_FEB_COMM, DAY_MAX);
    else if (pick < 18) dy = $urandom;
    else begin
      // leap day on a year near a leap boundary
      mon = MONTH_FEB;
      dy  = DAY_FEB_LEAP;
      yr  = ($urandom_range(0, 1) ? 4 : 100) * (int'($urandom_range(0, 600)) - 300);
    end
    send_word(act, amt, yr, mon, dy);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(ACT_DAYS, 0, 2024, 3, 1);
    send_word(ACT_DAYS, 1, 2024, 3, 1);
    send_word(ACT_DAYS, 1, 2023, 3, 1);
    send_word(ACT_DAYS, 1, 0, 1, 1);
    send_word(ACT_DAYS, 1, -32768, 1, 1);
    send_word(ACT_WEEKS, 1, 2000, 3, 5);
    send_word(ACT_MONTHS, 1, 2024, 3, 31);
    send_word(ACT_MONTHS, 3, 2023, 5, 31);
    send_word(ACT_YEARS_STEP, 4, 2024, 2, 29);
    send_word(ACT_YEARS_DIRECT, 4, 2024, 2, 29);
    send_word(ACT_DECADES_STEP, 1, 2000, 2, 29);
    send_word(ACT_DECADES_DIRECT, 40, 2000, 2, 29);
    send_word(ACT_CENTURY, 12345, 2000, 2, 29);
    send_word(ACT_MILLENNIUM, 0, 2400, 2, 29);
    send_word(ACT_YEARS_DIRECT, 0, -400, 2, 29);
    send_word(ACT_YEARS_DIRECT, 0, -100, 2, 29);
    send_word(ACT_DAYS, 0, 7, 0, 0);
    send_word(ACT_MONTHS, 1, 2023, 15, 31);
    send_word(ACT_WEEKS, 0, 2023, 2, 31);
    send_word(ACT_MILLENNIUM + 1'b1, 7, 2023, 2, 30);
    send_word({ACT_W{1'b1}}, 32767, -1, 4, 31);
    send_word(ACT_DECADES_DIRECT, 32767, 32767, 12, 31);
    send_word(ACT_DAYS, 32767, 32767, 12, 31);
    send_word(ACT_MONTHS, 32767, -1, 6, 30);
    send_word(ACT_YEARS_STEP, 32767, 0, 2, 29);
    send_word(ACT_DECADES_STEP, 32767, 2000, 2, 29);
    send_word(ACT_WEEKS, 32767, -32768, 1, 1);
    directed_words = words_sent;
    wait_drained();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      random_word();
      if (i % 100 == 99) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d directed) over %0d unit codes, incl. out-of-range dates",
             words_sent, directed_words, $countones(units_seen));
    $display("compared %0d result words, %0d mismatches", checked, failures);
    if (failures == 0) begin
      $display("tb_calendar_date_subtractor passed");
    end else begin
      $display("tb_calendar_date_subtractor failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/cds_pkg.sv
src/cds_datapath.sv
src/cds_ctrl.sv
src/calendar_date_subtractor.sv
verif/date_result_checker.sv
verif/tb_calendar_date_subtractor.sv
